[rtl/cal_clk_pkg.sv]
// ----------------------------------------------------------------------------
// cal_clk_pkg
// Types, constants and calendar helpers shared by the calendar clock counter.
// ----------------------------------------------------------------------------
package cal_clk_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    localparam logic [YEAR_W-1:0]   YEAR_MIN     = 12'd2020;
    localparam logic [YEAR_W-1:0]   YEAR_MAX     = 12'd2050;
    localparam logic [MONTH_W-1:0]  MONTH_LAST   = 4'd12;
    localparam logic [DAY_W-1:0]    DAY_LAST     = 5'd31;
    localparam logic [HOUR_W-1:0]   HOUR_LAST    = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST  = 6'd59;
    localparam logic [SECOND_W-1:0] SECOND_LAST  = 6'd59;

    localparam logic [YEAR_W-1:0]   RST_YEAR     = 12'd2024;
    localparam logic [MONTH_W-1:0]  RST_MONTH    = 4'd8;
    localparam logic [DAY_W-1:0]    RST_DAY      = 5'd30;
    localparam logic [HOUR_W-1:0]   RST_HOUR     = 5'd12;
    localparam logic [MINUTE_W-1:0] RST_MINUTE   = 6'd0;
    localparam logic [SECOND_W-1:0] RST_SECOND   = 6'd0;

    // reciprocal of 25 scaled by 2^17, exact for 12-bit years
    localparam int          RECIP25_SHIFT = 17;
    localparam logic [12:0] RECIP25       = 13'd5243;

    typedef struct packed {
        logic                opcode;
        logic [YEAR_W-1:0]   new_year;
        logic [MONTH_W-1:0]  new_month;
        logic [DAY_W-1:0]    new_day;
        logic [HOUR_W-1:0]   new_hour;
        logic [MINUTE_W-1:0] new_minute;
        logic [SECOND_W-1:0] new_second;
    } t_in_word;

    typedef struct packed {
        logic [YEAR_W-1:0]   cur_year;
        logic [MONTH_W-1:0]  cur_month;
        logic [DAY_W-1:0]    cur_day;
        logic [HOUR_W-1:0]   cur_hour;
        logic [MINUTE_W-1:0] cur_minute;
        logic [SECOND_W-1:0] cur_second;
        logic                rejected;
    } t_out_word;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } t_time;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [24:0]       prod;
        logic [7:0]        quot;
        logic [YEAR_W-1:0] q_ext;
        logic [YEAR_W-1:0] back;
        logic              div25;
        prod  = 25'(y) * 25'(RECIP25);
        quot  = prod[24:RECIP25_SHIFT];
        q_ext = {4'b0000, quot};
        back  = (q_ext << 4) + (q_ext << 3) + q_ext;
        div25 = (back == y);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[rtl/calendar_clock_counter_top.sv]
// ----------------------------------------------------------------------------
// calendar_clock_counter_top
// Calendar clock: each word is a one-second tick or a checked time load;
// every word returns the resulting time and a reject flag.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+-----------------------
//   input   | i_valid | o_stall | i_in_word  (t_in_word)
//   output  | o_valid | i_stall | o_out_word (t_out_word)
//
// one word per cycle while o_stall is low; a taken word passes the input
// register, then next-time logic into the result register
// reset loads 2024-08-30 12:00:00 and empties both registers
// o_stall rises only when the input register is full and the result register
// is full and stalled
// ----------------------------------------------------------------------------
module calendar_clock_counter_top
    import cal_clk_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_in_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_out_word
);

    logic      r_in_vld;
    t_in_word  r_in;
    logic      r_out_vld;
    t_out_word r_out;
    t_time     r_time;
    t_time     n_time;
    logic      n_rejected;
    logic      advance;

    assign advance = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && r_out_vld && i_stall;

    cal_clk_step u_step (
        .i_time     (r_time),
        .i_word     (r_in),
        .o_time     (n_time),
        .o_rejected (n_rejected)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= '{cur_year:   n_time.year,
                       cur_month:  n_time.month,
                       cur_day:    n_time.day,
                       cur_hour:   n_time.hour,
                       cur_minute: n_time.minute,
                       cur_second: n_time.second,
                       rejected:   n_rejected};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '{year:   RST_YEAR,
                        month:  RST_MONTH,
                        day:    RST_DAY,
                        hour:   RST_HOUR,
                        minute: RST_MINUTE,
                        second: RST_SECOND};
        end else if (advance) begin
            r_time <= n_time;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_out_word = r_out;

endmodule

[rtl/cal_clk_step.sv]
// ----------------------------------------------------------------------------
// cal_clk_step
// Next-time logic: one-second advance with calendar rollover, or a checked
// load of a new time.
// ----------------------------------------------------------------------------
module cal_clk_step
    import cal_clk_pkg::*;
(
    input  t_time    i_time,
    input  t_in_word i_word,
    output t_time    o_time,
    output logic     o_rejected
);

    t_time               tick_time;
    logic                sec_wrap;
    logic                min_wrap;
    logic                hour_wrap;
    logic [DAY_W:0]      day_inc;
    logic [DAY_W-1:0]    len;
    logic                day_over;
    logic                month_wrap;
    logic                set_ok;

    assign sec_wrap   = (i_time.second >= SECOND_LAST);
    assign min_wrap   = (i_time.minute >= MINUTE_LAST);
    assign hour_wrap  = (i_time.hour >= HOUR_LAST);
    assign day_inc    = {1'b0, i_time.day} + 6'd1;
    assign len        = month_len(i_time.month, is_leap(i_time.year));
    assign day_over   = (day_inc > {1'b0, len});
    assign month_wrap = (i_time.month >= MONTH_LAST);

    always_comb begin
        tick_time = i_time;
        if (sec_wrap) begin
            tick_time.second = '0;
            if (min_wrap) begin
                tick_time.minute = '0;
                if (hour_wrap) begin
                    tick_time.hour = '0;
                    if (day_over) begin
                        tick_time.day = 5'd1;
                        if (month_wrap) begin
                            tick_time.month = 4'd1;
                            tick_time.year  = i_time.year + 12'd1;
                        end else begin
                            tick_time.month = i_time.month + 4'd1;
                        end
                    end else begin
                        tick_time.day = day_inc[DAY_W-1:0];
                    end
                end else begin
                    tick_time.hour = i_time.hour + 5'd1;
                end
            end else begin
                tick_time.minute = i_time.minute + 6'd1;
            end
        end else begin
            tick_time.second = i_time.second + 6'd1;
        end
    end

    assign set_ok = (i_word.new_year >= YEAR_MIN) && (i_word.new_year <= YEAR_MAX)
                 && (i_word.new_month >= 4'd1) && (i_word.new_month <= MONTH_LAST)
                 && (i_word.new_day >= 5'd1) && (i_word.new_day <= DAY_LAST)
                 && (i_word.new_hour <= HOUR_LAST)
                 && (i_word.new_minute <= MINUTE_LAST)
                 && (i_word.new_second <= SECOND_LAST);

    always_comb begin
        o_time     = i_time;
        o_rejected = 1'b0;
        unique case (i_word.opcode)
            OP_TICK: o_time = tick_time;
            OP_SET: begin
                if (set_ok) begin
                    o_time.year   = i_word.new_year;
                    o_time.month  = i_word.new_month;
                    o_time.day    = i_word.new_day;
                    o_time.hour   = i_word.new_hour;
                    o_time.minute = i_word.new_minute;
                    o_time.second = i_word.new_second;
                end else begin
                    o_rejected = 1'b1;
                end
            end
            default: o_time = i_time;
        endcase
    end

endmodule
